### design/rhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhs_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned Q_W        = 8;
    localparam int unsigned N_W        = 11;
    localparam int unsigned HUE_NUM_W  = 19;
    localparam int unsigned HUE_DVS_W  = 11;
    localparam int unsigned SAT_NUM_W  = 16;
    localparam int unsigned SAT_DVS_W  = 8;
    localparam int unsigned HUE_MAX    = 254;
    localparam int unsigned SCALE      = 254;
    localparam int unsigned SECTORS    = 6;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_DVS_W-1:0] hue_dvs;
        logic [Q_W-1:0]       hue_q;
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [SAT_DVS_W-1:0] sat_dvs;
        logic [Q_W-1:0]       sat_q;
    } t_div;

endpackage

`default_nettype wire

### design/rhs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rhs_front import rhs_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    output logic                 o_valid,
    output t_div                 o_div
);

    // stage 1: max, min and sector
    logic [CH_W-1:0] w_mx;
    logic [CH_W-1:0] w_mn;
    t_sector         w_sec;

    logic            r_s1_valid;
    logic [CH_W-1:0] r_s1_red;
    logic [CH_W-1:0] r_s1_green;
    logic [CH_W-1:0] r_s1_blue;
    logic [CH_W-1:0] r_s1_mx;
    logic [CH_W-1:0] r_s1_mn;
    t_sector         r_s1_sec;

    always_comb begin
        w_mx = i_red;
        w_mn = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx)  w_mx = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn)  w_mn = i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            w_sec = SEC_RED;
        end else if (i_green >= i_blue) begin
            w_sec = SEC_GREEN;
        end else begin
            w_sec = SEC_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_mx    <= w_mx;
            r_s1_mn    <= w_mn;
            r_s1_sec   <= w_sec;
        end
    end

    // stage 2: delta and sector numerator
    logic [CH_W-1:0] w_d;
    logic [N_W-1:0]  w_d11;
    logic [N_W-1:0]  w_n;
    logic            r_s2_valid;
    logic [CH_W-1:0] r_s2_d;
    logic [N_W-1:0]  r_s2_n;
    logic [CH_W-1:0] r_s2_mx;

    always_comb begin
        w_d   = r_s1_mx - r_s1_mn;
        w_d11 = N_W'(w_d);
        case (r_s1_sec)
            SEC_RED: begin
                if (r_s1_green >= r_s1_blue) begin
                    w_n = N_W'(r_s1_green) - N_W'(r_s1_blue);
                end else begin
                    w_n = w_d11 * N_W'(SECTORS) - (N_W'(r_s1_blue) - N_W'(r_s1_green));
                end
            end
            SEC_GREEN: w_n = (w_d11 << 1) + N_W'(r_s1_blue) - N_W'(r_s1_red);
            SEC_BLUE:  w_n = (w_d11 << 2) + N_W'(r_s1_red) - N_W'(r_s1_green);
            default:   w_n = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_d  <= w_d;
            r_s2_n  <= w_n;
            r_s2_mx <= r_s1_mx;
        end
    end

    // stage 3: dividends and divisors
    logic            r_s3_valid;
    t_div            n_s3_div;
    t_div            r_s3_div;

    always_comb begin
        // floor((508n + 6d) / 12d) reduces to floor((254n + 3d) / 6d)
        n_s3_div.hue_q = '0;
        n_s3_div.sat_q = '0;
        if (r_s2_d == '0) begin
            n_s3_div.hue_rem = '0;
            n_s3_div.hue_dvs = HUE_DVS_W'(1);
        end else begin
            n_s3_div.hue_rem = HUE_NUM_W'(r_s2_n) * HUE_NUM_W'(SCALE)
                             + HUE_NUM_W'(r_s2_d) * HUE_NUM_W'(SECTORS / 2);
            n_s3_div.hue_dvs = HUE_DVS_W'(r_s2_d) * HUE_DVS_W'(SECTORS);
        end
        n_s3_div.sat_rem = SAT_NUM_W'(r_s2_d) * SAT_NUM_W'(SCALE);
        // black pixel: dividend is zero, keep the divisor nonzero
        n_s3_div.sat_dvs = (r_s2_mx == '0) ? SAT_DVS_W'(1) : r_s2_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_div <= n_s3_div;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_div   = r_s3_div;

endmodule

`default_nettype wire

### design/rhs_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rhs_div_stage import rhs_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_div i_div,
    output logic      o_valid,
    output t_div      o_div
);

    logic [HUE_NUM_W-1:0] w_hue_sh;
    logic [SAT_NUM_W-1:0] w_sat_sh;
    t_div                 n_div;
    logic                 r_valid;
    t_div                 r_div;

    // one restoring step for both quotients
    always_comb begin
        w_hue_sh = HUE_NUM_W'(i_div.hue_dvs) << BIT;
        w_sat_sh = SAT_NUM_W'(i_div.sat_dvs) << BIT;
        n_div    = i_div;
        if (i_div.hue_rem >= w_hue_sh) begin
            n_div.hue_rem    = i_div.hue_rem - w_hue_sh;
            n_div.hue_q[BIT] = 1'b1;
        end
        if (i_div.sat_rem >= w_sat_sh) begin
            n_div.sat_rem    = i_div.sat_rem - w_sat_sh;
            n_div.sat_q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

`default_nettype wire

### design/rgb_to_hue_saturation_top.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB pixel to hue and saturation, both on a 0..254 scale (hue 0 for grey,
// saturation 0 for grey or black). One pixel per clock is accepted; the pipe
// has three front stages (max/min/sector, then delta and sector
// numerator, then dividends and divisors) followed by eight
// restoring-division stages, one quotient bit each, that compute hue and
// saturation side by side. The whole pipe advances together and holds when
// the result register is full and not taken, so o_ready is high whenever
// the output is empty or being taken.
module rgb_to_hue_saturation_top import rhs_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [Q_W-1:0]       o_hue,
    output logic [Q_W-1:0]       o_saturation
);

    logic w_en;
    logic w_vld [Q_W+1];
    t_div w_div [Q_W+1];

    assign w_en    = !w_vld[Q_W] || i_ready;
    assign o_ready = w_en;

    rhs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_vld[0]),
        .o_div   (w_div[0])
    );

    for (genvar gi = 0; gi < Q_W; gi++) begin : g_div
        rhs_div_stage #(
            .BIT (Q_W - 1 - gi)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[gi]),
            .i_div   (w_div[gi]),
            .o_valid (w_vld[gi+1]),
            .o_div   (w_div[gi+1])
        );
    end

    assign o_valid      = w_vld[Q_W];
    assign o_hue        = w_div[Q_W].hue_q;
    assign o_saturation = w_div[Q_W].sat_q;

    // a finished division leaves less than one divisor behind
    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_div[Q_W].hue_rem < HUE_NUM_W'(w_div[Q_W].hue_dvs)))
        else $error("hue remainder not below divisor");

    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_div[Q_W].sat_rem < SAT_NUM_W'(w_div[Q_W].sat_dvs)))
        else $error("saturation remainder not below divisor");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue <= Q_W'(HUE_MAX)))
        else $error("hue above full scale");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= Q_W'(SCALE)))
        else $error("saturation above full scale");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rhs_pkg::*;

    localparam int unsigned RANDOM_PIXELS = 1880;
    localparam int unsigned QUIET_PIXELS  = 250;
    localparam int unsigned PIPE_SETTLE   = 24;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [Q_W-1:0] hue;
        logic [Q_W-1:0] sat;
    } hs_pair_t;

    class hue_sat_scoreboard;
        hs_pair_t    expected_hs[$];
        int unsigned errors;

        function hs_pair_t convert(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b);
            int unsigned rv, gv, bv, mx, mn, d, num, h;
            t_sector     sec;
            hs_pair_t    res;
            rv = r;
            gv = g;
            bv = b;
            mx = rv;
            mn = rv;
            if (gv > mx) mx = gv;
            if (bv > mx) mx = bv;
            if (gv < mn) mn = gv;
            if (bv < mn) mn = bv;
            d = mx - mn;
            res.sat = (mx == 0) ? '0 : Q_W'((d * SCALE) / mx);
            if (d == 0) begin
                res.hue = '0;
            end else begin
                // ties go to red, then green
                if (rv == mx) sec = SEC_RED;
                else if (gv == mx) sec = SEC_GREEN;
                else sec = SEC_BLUE;
                case (sec)
                    SEC_RED:   num = (gv >= bv) ? gv - bv : SECTORS * d - (bv - gv);
                    SEC_GREEN: num = (2 * d + bv) - rv;
                    default:   num = (4 * d + rv) - gv;
                endcase
                // round half up of num/d * scale/sectors
                h = (2 * SCALE * num + SECTORS * d) / (2 * SECTORS * d);
                res.hue = (h > HUE_MAX) ? Q_W'(HUE_MAX) : Q_W'(h);
            end
            return res;
        endfunction

        function void note_pixel(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b);
            expected_hs.push_back(convert(r, g, b));
        endfunction

        function void check_result(logic [Q_W-1:0] hue, logic [Q_W-1:0] sat);
            hs_pair_t exp_hs;
            if (expected_hs.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d", hue, sat);
                errors++;
                return;
            end
            exp_hs = expected_hs.pop_front();
            if (hue !== exp_hs.hue) begin
                $error("hue: expected %0d, actual %0d", exp_hs.hue, hue);
                errors++;
            end
            if (sat !== exp_hs.sat) begin
                $error("saturation: expected %0d, actual %0d", exp_hs.sat, sat);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_hs.size();
        endfunction
    endclass

    logic            i_clk        = 1'b0;
    logic            i_rst_n      = 1'b0;
    logic            i_valid      = 1'b0;
    logic            i_ready      = 1'b0;
    logic [CH_W-1:0] i_red        = '0;
    logic [CH_W-1:0] i_green      = '0;
    logic [CH_W-1:0] i_blue       = '0;
    logic            o_ready;
    logic            o_valid;
    logic [Q_W-1:0]  o_hue;
    logic [Q_W-1:0]  o_saturation;

    hue_sat_scoreboard board;
    bit                quiet = 1'b0;
    int unsigned       cycle_count = 0;
    int unsigned       ready_left = 0;
    bit                ready_next = 1'b0;

    rgb_to_hue_saturation_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_result(o_hue, o_saturation);
        if (ready_left == 0) begin
            if (quiet || !ready_next) begin
                ready_next = 1'b1;
                ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
            end else begin
                ready_next = 1'b0;
                ready_left = $urandom_range(1, 12);
            end
        end
        ready_left--;
        i_ready <= ready_next;
    end

    task automatic send_pixel(input bit [CH_W-1:0] r, input bit [CH_W-1:0] g,
                              input bit [CH_W-1:0] b);
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        board.note_pixel(r, g, b);
    endtask

    task automatic hold_input(input int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        bit [CH_W-1:0] r, g, b;
        int            base;
        bit            gaps_on;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, greys, primaries, ties between channels, hue near a full turn
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd0,   8'd1);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd0,   8'd128, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd150);
        wait_drained();

        gaps_on = 1'b1;
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS / 2) wait_drained();
            if (i % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 7))
                4: begin
                    // near grey
                    base = $urandom_range(3, 252);
                    r = CH_W'(base + $urandom_range(0, 6) - 3);
                    g = CH_W'(base + $urandom_range(0, 6) - 3);
                    b = CH_W'(base + $urandom_range(0, 6) - 3);
                end
                5: begin
                    // two channels equal
                    base = $urandom_range(0, 255);
                    r = CH_W'($urandom_range(0, 255));
                    g = CH_W'(base);
                    b = CH_W'(base);
                    case ($urandom_range(0, 2))
                        0: begin g = r; r = CH_W'(base); end
                        1: begin b = r; r = CH_W'(base); end
                        default: ;
                    endcase
                end
                6: begin
                    r = CH_W'($urandom_range(0, 3));
                    g = CH_W'($urandom_range(0, 3));
                    b = CH_W'($urandom_range(0, 3));
                end
                7: begin
                    r = ($urandom_range(0, 1) == 0) ? 8'd255 : CH_W'($urandom_range(0, 1));
                    g = CH_W'($urandom_range(0, 255));
                    b = ($urandom_range(0, 1) == 0) ? 8'd254 : CH_W'($urandom_range(0, 2));
                end
                default: begin
                    r = CH_W'($urandom_range(0, 255));
                    g = CH_W'($urandom_range(0, 255));
                    b = CH_W'($urandom_range(0, 255));
                end
            endcase
            send_pixel(r, g, b);
            if (i >= RANDOM_PIXELS - QUIET_PIXELS) quiet = 1'b1;
            if (!quiet && gaps_on && $urandom_range(0, 3) == 0)
                hold_input($urandom_range(1, 12));
        end

        wait_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
